// ===== rtl/input_restricted_circular_deque_unit_macros.svh =====
// Assertion macros for the input-restricted circular deque unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INPUT_RESTRICTED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define INPUT_RESTRICTED_CIRCULAR_DEQUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define IRCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deque check failed");
// Next-cycle implication, disabled while reset is asserted.
`define IRCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deque check failed");
`else
`define IRCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define IRCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/ircd_pkg.sv =====
// Shared types and constants for the input-restricted circular deque unit.
// No dependencies.
`timescale 1ns / 1ps
package ircd_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DEL_FRONT = 2'd1,
    CMD_DEL_REAR  = 2'd2,
    CMD_DUMP      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

  localparam word_t VALUE_EMPTY = '1;
  localparam word_t VALUE_NONE  = '0;

  // Per-cell control: load takes the incoming item, wrap takes the head
  // cell's word, shift takes the right-hand neighbor's word.
  typedef struct packed {
    logic load;
    logic wrap;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/ircd_cell.sv =====
// One storage cell of the deque chain: a 32-bit word register.
// Depends on ircd_pkg.
`timescale 1ns / 1ps
module ircd_cell (
  input  logic               clk,
  input  ircd_pkg::cell_ctl_t ctl,
  input  ircd_pkg::word_t    in_d,
  input  ircd_pkg::word_t    wrap_d,
  input  ircd_pkg::word_t    right_d,
  output ircd_pkg::word_t    q
);

  ircd_pkg::word_t word_r;
  ircd_pkg::word_t word_nxt;

  always_comb begin
    priority if (ctl.load) begin
      word_nxt = in_d;
    end else if (ctl.wrap) begin
      word_nxt = wrap_d;
    end else if (ctl.shift) begin
      word_nxt = right_d;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

// ===== rtl/input_restricted_circular_deque_unit.sv =====
// Top level of the input-restricted circular deque unit: command decode,
// the row of storage cells and the output register.
// Depends on ircd_pkg, ircd_cell and input_restricted_circular_deque_unit_macros.svh.
`timescale 1ns / 1ps
`include "input_restricted_circular_deque_unit_macros.svh"
//
//   Channel | Ports        | Payload
//   --------+--------------+-------------------------------------------
//   input   | in_t*        | tuser: command; tdata: data_in
//   result  | out_t*       | tdata: value_out, status; tlast: last
//
// Insert, delete front and delete rear each produce one result, which sits
// in the output register; a new command is accepted in the same cycle that
// the previous result is taken.
// Dump is accepted and then sends one result per stored item: the chain
// rotates left by one cell per transfer, so the item count sets the number
// of transfers. The chain returns to its original order once the dump ends.
// Reset (synchronous, active low) empties the deque; cell contents are
// not cleared. A stalled result holds the output register and all state.
module input_restricted_circular_deque_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value_out, [33:32] status, [39:34] zero
  output logic        out_tlast
);

  // Count runs from zero to DEPTH inclusive; a cell index needs one bit less
  // at power-of-two depths.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ircd_pkg::word_t      out_value_r, out_value_nxt;
  ircd_pkg::status_t    out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  ircd_pkg::word_t      cell_q [DEPTH];
  ircd_pkg::cell_ctl_t  cell_ctl [DEPTH];

  ircd_pkg::cmd_t       cmd;
  ircd_pkg::word_t      data_in;
  logic                 slot_free;
  logic                 in_fire;
  logic                 dump_step;
  logic [CW-1:0]        rear_pos;
  ircd_pkg::word_t      rear_q;
  logic                 do_load;
  logic                 do_shift;
  logic                 do_rotate;

  assign cmd       = ircd_pkg::cmd_t'(in_tuser);
  assign data_in   = ircd_pkg::word_t'(in_tdata);
  // The output register frees up either when empty or when its result moves on.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign dump_step = (state_r == ST_DUMP) && slot_free;

  // The front item always lives in cell zero and the rear item in the cell
  // just below the count.
  assign rear_pos = count_r - ONE_COUNT;
  assign rear_q   = cell_q[rear_pos[IW-1:0]];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    do_load        = 1'b0;
    do_shift       = 1'b0;
    do_rotate      = 1'b0;

    if (in_fire) begin
      unique case (cmd)
        ircd_pkg::CMD_INSERT: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = ircd_pkg::VALUE_NONE;
          out_last_nxt  = 1'b1;
          if (count_r == FULL_COUNT) begin
            out_status_nxt = ircd_pkg::STAT_OVERFLOW;
          end else begin
            out_status_nxt = ircd_pkg::STAT_OK;
            do_load        = 1'b1;
            count_nxt      = count_r + ONE_COUNT;
          end
        end
        ircd_pkg::CMD_DEL_FRONT: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (count_r == '0) begin
            out_value_nxt  = ircd_pkg::VALUE_EMPTY;
            out_status_nxt = ircd_pkg::STAT_EMPTY;
          end else begin
            // Every cell takes its right-hand neighbor, dropping the front.
            out_value_nxt  = cell_q[0];
            out_status_nxt = ircd_pkg::STAT_OK;
            do_shift       = 1'b1;
            count_nxt      = count_r - ONE_COUNT;
          end
        end
        ircd_pkg::CMD_DEL_REAR: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (count_r == '0) begin
            out_value_nxt  = ircd_pkg::VALUE_EMPTY;
            out_status_nxt = ircd_pkg::STAT_EMPTY;
          end else begin
            out_value_nxt  = rear_q;
            out_status_nxt = ircd_pkg::STAT_OK;
            count_nxt      = count_r - ONE_COUNT;
          end
        end
        ircd_pkg::CMD_DUMP: begin
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = ircd_pkg::VALUE_EMPTY;
            out_status_nxt = ircd_pkg::STAT_EMPTY;
            out_last_nxt   = 1'b1;
          end else begin
            state_nxt = ST_DUMP;
            rem_nxt   = count_r;
          end
        end
        default: begin
        end
      endcase
    end else if (dump_step) begin
      // Send the front word and rotate it around to the rear cell.
      out_valid_nxt  = 1'b1;
      out_value_nxt  = cell_q[0];
      out_status_nxt = ircd_pkg::STAT_OK;
      out_last_nxt   = (rem_r == ONE_COUNT);
      do_rotate      = 1'b1;
      rem_nxt        = rem_r - ONE_COUNT;
      if (rem_r == ONE_COUNT) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].load  = do_load && (CW'(i) == count_r);
      cell_ctl[i].wrap  = do_rotate && (CW'(i) == rear_pos);
      cell_ctl[i].shift = do_shift || (do_rotate && (CW'(i) != rear_pos));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ircd_pkg::word_t right_d;
    if (g == DEPTH - 1) begin : g_end
      assign right_d = cell_q[g];
    end else begin : g_mid
      assign right_d = cell_q[g+1];
    end
    ircd_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[g]),
      .in_d    (data_in),
      .wrap_d  (cell_q[0]),
      .right_d (right_d),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_value_r};
  assign out_tlast  = out_last_r;

  // The item count never passes the number of cells.
  `IRCD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_COUNT)
  // A dump in progress always has items left to send.
  `IRCD_ASSERT_IMPL(a_dump_rem, clk, rst_n, state_r == ST_DUMP, rem_r != '0)
  // An insert into a full deque reports overflow and leaves the count alone.
  `IRCD_ASSERT_NEXT(a_overflow, clk, rst_n,
                    in_fire && cmd == ircd_pkg::CMD_INSERT && count_r == FULL_COUNT,
                    out_valid_r && out_status_r == ircd_pkg::STAT_OVERFLOW && $stable(count_r))
  // The final dump transfer carries last and returns to idle.
  `IRCD_ASSERT_NEXT(a_dump_end, clk, rst_n, dump_step && rem_r == ONE_COUNT,
                    out_last_r && state_r == ST_IDLE)

endmodule

// ===== verif/deque_result_checker.sv =====
// Result checker for the input-restricted circular deque unit: follows the command stream,
// predicts every result and compares the result stream against those predictions.
// Depends on ircd_pkg.
`timescale 1ns / 1ps
module deque_result_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] value_out, [33:32] status, [39:34] zero
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    ircd_pkg::word_t   value;
    ircd_pkg::status_t status;
    logic              last;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers.
  ircd_pkg::word_t ring_words [DEPTH];
  int              front_slot;
  int              rear_slot;
  logic            deque_empty;

  deque_result_t expected_results [$];
  int errors;
  int results_seen;

  function automatic int slot_after(int i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int slot_before(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic deque_result_t make_result(ircd_pkg::word_t v, ircd_pkg::status_t s,
                                                logic l);
    deque_result_t r;
    r.value  = v;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  task automatic clear_deque();
    deque_empty = 1'b1;
    front_slot  = 0;
    rear_slot   = 0;
  endtask

  // Applies one command to the shadow deque and queues the results it causes.
  task automatic predict_deque_op(ircd_pkg::cmd_t op, ircd_pkg::word_t data);
    int              idx;
    int              n;
    logic            fin;
    ircd_pkg::word_t taken;
    case (op)
      ircd_pkg::CMD_INSERT: begin
        if (deque_empty) begin
          deque_empty = 1'b0;
          front_slot  = 0;
          rear_slot   = 0;
          ring_words[0] = data;
          expected_results.push_back(
            make_result(ircd_pkg::VALUE_NONE, ircd_pkg::STAT_OK, 1'b1));
        end else if (slot_after(rear_slot) == front_slot) begin
          expected_results.push_back(
            make_result(ircd_pkg::VALUE_NONE, ircd_pkg::STAT_OVERFLOW, 1'b1));
        end else begin
          rear_slot = slot_after(rear_slot);
          ring_words[rear_slot] = data;
          expected_results.push_back(
            make_result(ircd_pkg::VALUE_NONE, ircd_pkg::STAT_OK, 1'b1));
        end
      end
      ircd_pkg::CMD_DEL_FRONT, ircd_pkg::CMD_DEL_REAR: begin
        if (deque_empty) begin
          expected_results.push_back(
            make_result(ircd_pkg::VALUE_EMPTY, ircd_pkg::STAT_EMPTY, 1'b1));
        end else begin
          if (op == ircd_pkg::CMD_DEL_FRONT)
            taken = ring_words[front_slot];
          else
            taken = ring_words[rear_slot];
          if (front_slot == rear_slot) begin
            clear_deque();
          end else if (op == ircd_pkg::CMD_DEL_FRONT) begin
            front_slot = slot_after(front_slot);
          end else begin
            rear_slot = slot_before(rear_slot);
          end
          expected_results.push_back(make_result(taken, ircd_pkg::STAT_OK, 1'b1));
        end
      end
      default: begin
        if (deque_empty) begin
          expected_results.push_back(
            make_result(ircd_pkg::VALUE_EMPTY, ircd_pkg::STAT_EMPTY, 1'b1));
        end else begin
          idx = front_slot;
          for (n = 0; n < DEPTH; n++) begin
            fin = (idx == rear_slot) || (n == DEPTH - 1);
            expected_results.push_back(make_result(ring_words[idx], ircd_pkg::STAT_OK, fin));
            if (fin) break;
            idx = slot_after(idx);
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] result %0d: %s mismatch, got %h, expected %h",
             $realtime, results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      clear_deque();
      expected_results.delete();
      errors       = 0;
      results_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (ircd_pkg::word_t'(out_tdata[31:0]) !== want.value)
            report_mismatch("value_out", out_tdata[31:0], want.value);
          if (out_tdata[33:32] !== want.status)
            report_mismatch("status", out_tdata[33:32], want.status);
          if (out_tlast !== want.last)
            report_mismatch("last", out_tlast, want.last);
          if (out_tdata[39:34] !== 6'd0)
            report_mismatch("padding", out_tdata[39:34], 0);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready)
        predict_deque_op(ircd_pkg::cmd_t'(in_tuser), ircd_pkg::word_t'(in_tdata));
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

// ===== verif/input_restricted_circular_deque_unit_tb.sv =====
// Testbench top for the input-restricted circular deque unit: clock, reset, command
// stimulus, result back-pressure and the final verdict.
// Depends on ircd_pkg, deque_result_checker and the unit under test.
`timescale 1ns / 1ps
module input_restricted_circular_deque_unit_tb;

  localparam int unsigned DEPTH = 8;
  // Random commands after the directed opening.
  localparam int RANDOM_CMDS = 260;
  // Worst case is every command a full dump with the receiver mostly stalled; this
  // bound is many times that.
  localparam int CYCLE_LIMIT = 400000;
  // Quiet cycles after the last expected result, to catch stray extra results.
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] data_in
  logic [1:0]  in_tuser;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] value_out, [33:32] status, [39:34] zero
  logic        out_tlast;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;

  // Percent of cycles in which each side holds back; changed between phases.
  int send_idle_pct;
  int recv_idle_pct;

  input_restricted_circular_deque_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // The checker watches both channels beside the block and reports back only a
  // mismatch count and the number of results still owed.
  deque_result_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL input_restricted_circular_deque_unit");
      $finish;
    end
  end

  // Result side: ready is redrawn once per falling edge, so stalls land on every
  // beat of a dump as well as on single results.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one command and returns at the falling edge after its transfer. Idle
  // cycles are inserted before the offer; valid is written once per edge, so a
  // back-to-back command keeps valid high without a glitch.
  task automatic send_cmd(ircd_pkg::cmd_t op, ircd_pkg::word_t data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Mostly random words, with the signed extremes, zero and minus one mixed in.
  function automatic ircd_pkg::word_t pick_word();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int             k;
    int             run_left;
    int             insert_pct;
    int             r;
    ircd_pkg::cmd_t op;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tuser      = ircd_pkg::CMD_INSERT;
    in_tdata      = '0;
    send_idle_pct = 11;
    recv_idle_pct = 79;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening. Every kind of command on an empty deque first.
    send_cmd(ircd_pkg::CMD_DEL_FRONT, $urandom);
    send_cmd(ircd_pkg::CMD_DEL_REAR, $urandom);
    send_cmd(ircd_pkg::CMD_DUMP, $urandom);
    // Deleting the only item from either end must leave the deque empty again.
    send_cmd(ircd_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_cmd(ircd_pkg::CMD_DEL_FRONT, $urandom);
    send_cmd(ircd_pkg::CMD_INSERT, 32'h8000_0000);
    send_cmd(ircd_pkg::CMD_DEL_REAR, $urandom);
    // Fill to capacity, starting with the extreme values.
    for (k = 0; k < DEPTH; k++) begin
      case (k)
        0: send_cmd(ircd_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        1: send_cmd(ircd_pkg::CMD_INSERT, 32'h8000_0000);
        2: send_cmd(ircd_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        3: send_cmd(ircd_pkg::CMD_INSERT, 32'h0000_0000);
        default: send_cmd(ircd_pkg::CMD_INSERT, $urandom);
      endcase
    end
    // An insert into a full deque is refused; a dump of a full deque gives every slot.
    send_cmd(ircd_pkg::CMD_INSERT, $urandom);
    send_cmd(ircd_pkg::CMD_DUMP, $urandom);
    // Move the front off slot zero, then let the rear wrap onto slot zero and
    // delete it there, so the rear pointer wraps backward to the top slot.
    send_cmd(ircd_pkg::CMD_DEL_FRONT, $urandom);
    send_cmd(ircd_pkg::CMD_DEL_FRONT, $urandom);
    send_cmd(ircd_pkg::CMD_INSERT, $urandom);
    send_cmd(ircd_pkg::CMD_DEL_REAR, $urandom);
    send_cmd(ircd_pkg::CMD_DUMP, $urandom);

    // Random part. The mix alternates between runs that lean toward inserts and
    // runs that lean toward deletes, so the deque keeps swinging between empty
    // and full and the pointers wrap in both directions.
    run_left   = 0;
    insert_pct = 50;
    for (k = 0; k < RANDOM_CMDS; k++) begin
      if (k == RANDOM_CMDS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 11;
      end else if (k == 2 * RANDOM_CMDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (run_left == 0) begin
        run_left   = $urandom_range(12, 30);
        insert_pct = (insert_pct > 50) ? $urandom_range(25, 40) : $urandom_range(60, 75);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 10)
        op = ircd_pkg::CMD_DUMP;
      else if (r < 10 + insert_pct * 90 / 100)
        op = ircd_pkg::CMD_INSERT;
      else if ($urandom_range(1) == 0)
        op = ircd_pkg::CMD_DEL_FRONT;
      else
        op = ircd_pkg::CMD_DEL_REAR;
      send_cmd(op, pick_word());
    end
    in_tvalid <= 1'b0;

    // Wait for every owed result, then a few more cycles for anything extra.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS input_restricted_circular_deque_unit");
    end else begin
      $display("FAIL input_restricted_circular_deque_unit");
    end
    $finish;
  end

endmodule
